@@ hdl/dbsd_pkg.sv @@
// ----------------------------------------------------------------------------
// dbsd_pkg
// shared helpers for the box and score decode: sigmoid table generation and
// corner saturation
// ----------------------------------------------------------------------------
package dbsd_pkg;

    localparam int unsigned CORNER_W  = 28;
    localparam int unsigned PROD_W    = 29;
    localparam int unsigned PROB_W    = 16;
    localparam int unsigned FRAC_W    = 15;
    localparam int unsigned ROM_W     = 32;

    localparam logic [CORNER_W-1:0] CORNER_MAX = {1'b0, {(CORNER_W-1){1'b1}}};
    localparam logic [CORNER_W-1:0] CORNER_MIN = {1'b1, {(CORNER_W-1){1'b0}}};

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // result kind carried in tuser
    typedef enum logic {
        KIND_BOX   = 1'b0,
        KIND_SCORE = 1'b1
    } t_kind;

    // restoring divide, elaboration use only
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(-y) in q30 by a 21-term series
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] y);
        logic [63:0] term;
        logic [63:0] sum;
        term = Q30_ONE;
        sum  = Q30_ONE;
        for (int k = 1; k <= 20; k++) begin
            term = div_u64((term * y) >> 30, 64'(k));
            if ((k % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // round(65536 * sigmoid(8 * i / n)), capped at 65535
    function automatic logic [PROB_W-1:0] sig_entry(input int i, input int n);
        logic [63:0] y;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] p;
        y   = div_u64(64'(i) << 30, 64'(n));
        e   = exp_neg_q30(y);
        e   = (e * e) >> 30;
        e   = (e * e) >> 30;
        e   = (e * e) >> 30;
        den = Q30_ONE + e;
        p   = div_u64((64'd1 << 47) + den, den << 1);
        if (p > 64'd65535) begin
            p = 64'd65535;
        end
        return p[PROB_W-1:0];
    endfunction

    // clamp a stride product into the 28-bit corner range
    function automatic logic [CORNER_W-1:0] sat_corner(input logic signed [PROD_W-1:0] v);
        logic [CORNER_W-1:0] res;
        if (v[PROD_W-1] != v[PROD_W-2]) begin
            res = v[PROD_W-1] ? CORNER_MIN : CORNER_MAX;
        end else begin
            res = v[CORNER_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ hdl/dbsd_sig_rom.sv @@
// ----------------------------------------------------------------------------
// dbsd_sig_rom
// sigmoid segment table, registered read; each entry holds the segment base
// in the upper half and the rise to the next point in the lower half
// ----------------------------------------------------------------------------
module dbsd_sig_rom
    import dbsd_pkg::*;
#(
    parameter int ENTRIES = 256,
    localparam int ADDR_W = $clog2(ENTRIES + 1)
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [ADDR_W-1:0] i_addr,
    output logic [ROM_W-1:0]  o_data
);

    logic [ROM_W-1:0] w_rom [0:ENTRIES];
    logic [ROM_W-1:0] r_data;

    for (genvar g = 0; g <= ENTRIES; g++) begin : g_rom
        if (g == ENTRIES) begin : g_last
            // saturated end point: no rise
            assign w_rom[g] = {sig_entry(g, ENTRIES), {PROB_W{1'b0}}};
        end else begin : g_seg
            localparam logic [PROB_W-1:0] LO = sig_entry(g, ENTRIES);
            localparam logic [PROB_W-1:0] HI = sig_entry(g + 1, ENTRIES);
            assign w_rom[g] = {LO, (HI >= LO) ? PROB_W'(HI - LO) : {PROB_W{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= w_rom[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

@@ hdl/detection_box_and_score_decode.sv @@
// ----------------------------------------------------------------------------
// detection_box_and_score_decode
// ltrb box decode and sigmoid class score for an anchor-free detector head
// ----------------------------------------------------------------------------
// Takes one word per clock while tready is high and returns one result word
// per word taken, in order. A box word (tuser 0) gives the corners anchor-left,
// anchor-top, anchor+right, anchor+bottom times the integer stride, each
// saturated to 28-bit signed, probability zero. A score word (tuser 1) gives
// the sigmoid of a Q4.12 logit in Q0.16 from a linearly interpolated table of
// SIGMOID_TABLE_ENTRIES segments over [0, 8], mirrored for negative logits,
// corners zero. The four stages are: operand prep and table index, table read
// and stride multiply, saturation and interpolation multiply, final add.
// Every stage holds its word on its own when the next one is full, so the
// pipeline fills all four slots before tready drops; throughput is set by
// nothing but the output handshake. The table is built at elaboration.
// ----------------------------------------------------------------------------
module detection_box_and_score_decode
    import dbsd_pkg::*;
#(
    parameter int SIGMOID_TABLE_ENTRIES = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // left_dist, top_dist, right_dist, bottom_dist, anchor_x, anchor_y,
    // level_stride, class_logit, 3 zero bits
    input  logic [143:0] s_axis_tdata,
    // action
    input  logic [0:0]   s_axis_tuser,

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // x_min, y_min, x_max, y_max, probability
    output logic [127:0] m_axis_tdata,
    // result_kind
    output logic [0:0]   m_axis_tuser
);

    localparam int IDX_W  = $clog2(SIGMOID_TABLE_ENTRIES + 1);
    localparam int POS_W  = 17 + IDX_W;
    localparam int IDXF_W = POS_W - FRAC_W;
    localparam int SUM_W  = 21;

    // ---------------- input unpack ----------------
    logic signed [19:0] w_left, w_top, w_right, w_bottom;
    logic        [18:0] w_ax, w_ay;
    logic        [6:0]  w_stride;
    logic signed [15:0] w_logit;

    assign w_left   = s_axis_tdata[19:0];
    assign w_top    = s_axis_tdata[39:20];
    assign w_right  = s_axis_tdata[59:40];
    assign w_bottom = s_axis_tdata[79:60];
    assign w_ax     = s_axis_tdata[98:80];
    assign w_ay     = s_axis_tdata[117:99];
    assign w_stride = s_axis_tdata[124:118];
    assign w_logit  = s_axis_tdata[140:125];

    // ---------------- stage advance chain ----------------
    // each stage loads when it is empty or its successor is loading
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_adv1, w_adv2, w_adv3, w_adv4;

    assign w_adv4 = !r_v4 || m_axis_tready;
    assign w_adv3 = !r_v3 || w_adv4;
    assign w_adv2 = !r_v2 || w_adv3;
    assign w_adv1 = !r_v1 || w_adv2;

    assign s_axis_tready = w_adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= s_axis_tvalid;
            if (w_adv2) r_v2 <= r_v1;
            if (w_adv3) r_v3 <= r_v2;
            if (w_adv4) r_v4 <= r_v3;
        end
    end

    // ---------------- stage 1: anchor sums, logit magnitude, table index ----------------
    logic signed [SUM_W-1:0] w_x_lo, w_y_lo, w_x_hi, w_y_hi;
    logic        [16:0]      w_mag;
    logic        [POS_W-1:0] w_pos;
    logic        [IDX_W-1:0] w_idx;

    assign w_x_lo = $signed({2'b00, w_ax}) - SUM_W'(w_left);
    assign w_y_lo = $signed({2'b00, w_ay}) - SUM_W'(w_top);
    assign w_x_hi = $signed({2'b00, w_ax}) + SUM_W'(w_right);
    assign w_y_hi = $signed({2'b00, w_ay}) + SUM_W'(w_bottom);

    // |logit| needs 17 bits for the most negative code
    assign w_mag = w_logit[15] ? (17'd0 - 17'(w_logit)) : 17'(w_logit);
    assign w_pos = POS_W'(w_mag) * POS_W'(SIGMOID_TABLE_ENTRIES);

    // magnitudes of 8 or more read the end point
    always_comb begin
        if (w_pos[POS_W-1:FRAC_W] >= IDXF_W'(SIGMOID_TABLE_ENTRIES)) begin
            w_idx = IDX_W'(SIGMOID_TABLE_ENTRIES);
        end else begin
            w_idx = w_pos[FRAC_W+IDX_W-1:FRAC_W];
        end
    end

    t_kind                   r_s1_kind;
    logic signed [SUM_W-1:0] r_s1_x_lo, r_s1_y_lo, r_s1_x_hi, r_s1_y_hi;
    logic        [6:0]       r_s1_stride;
    logic                    r_s1_neg;
    logic        [IDX_W-1:0] r_s1_idx;
    logic        [FRAC_W-1:0] r_s1_frac;

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_s1_kind   <= t_kind'(s_axis_tuser[0]);
            r_s1_x_lo   <= w_x_lo;
            r_s1_y_lo   <= w_y_lo;
            r_s1_x_hi   <= w_x_hi;
            r_s1_y_hi   <= w_y_hi;
            r_s1_stride <= w_stride;
            r_s1_neg    <= w_logit[15];
            r_s1_idx    <= w_idx;
            r_s1_frac   <= w_pos[FRAC_W-1:0];
        end
    end

    // ---------------- stage 2: table read, stride multiply ----------------
    logic [ROM_W-1:0] w_rom_data;

    dbsd_sig_rom #(
        .ENTRIES (SIGMOID_TABLE_ENTRIES)
    ) u_sig_rom (
        .i_clk  (i_clk),
        .i_en   (w_adv2),
        .i_addr (r_s1_idx),
        .o_data (w_rom_data)
    );

    logic signed [PROD_W-1:0] w_stride_s;
    assign w_stride_s = $signed(PROD_W'({1'b0, r_s1_stride}));

    t_kind                    r_s2_kind;
    logic signed [PROD_W-1:0] r_s2_px_lo, r_s2_py_lo, r_s2_px_hi, r_s2_py_hi;
    logic                     r_s2_neg;
    logic        [FRAC_W-1:0] r_s2_frac;

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_s2_kind  <= r_s1_kind;
            r_s2_px_lo <= PROD_W'(r_s1_x_lo) * w_stride_s;
            r_s2_py_lo <= PROD_W'(r_s1_y_lo) * w_stride_s;
            r_s2_px_hi <= PROD_W'(r_s1_x_hi) * w_stride_s;
            r_s2_py_hi <= PROD_W'(r_s1_y_hi) * w_stride_s;
            r_s2_neg   <= r_s1_neg;
            r_s2_frac  <= r_s1_frac;
        end
    end

    // ---------------- stage 3: corner saturation, interpolation multiply ----------------
    t_kind                          r_s3_kind;
    logic [CORNER_W-1:0]            r_s3_x_min, r_s3_y_min, r_s3_x_max, r_s3_y_max;
    logic                           r_s3_neg;
    logic [PROB_W-1:0]              r_s3_lo;
    logic [PROB_W+FRAC_W-1:0]       r_s3_step;

    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r_s3_kind  <= r_s2_kind;
            r_s3_x_min <= sat_corner(r_s2_px_lo);
            r_s3_y_min <= sat_corner(r_s2_py_lo);
            r_s3_x_max <= sat_corner(r_s2_px_hi);
            r_s3_y_max <= sat_corner(r_s2_py_hi);
            r_s3_neg   <= r_s2_neg;
            r_s3_lo    <= w_rom_data[ROM_W-1:PROB_W];
            r_s3_step  <= (PROB_W+FRAC_W)'(w_rom_data[PROB_W-1:0]) *
                          (PROB_W+FRAC_W)'(r_s2_frac);
        end
    end

    // ---------------- stage 4: rounding add, mirror, output register ----------------
    logic [PROB_W+FRAC_W:0] w_step_rnd;
    logic [PROB_W:0]        w_s;
    logic [PROB_W:0]        w_p;
    logic [PROB_W-1:0]      w_prob;

    assign w_step_rnd = (PROB_W+FRAC_W+1)'(r_s3_step) + (PROB_W+FRAC_W+1)'(16384);
    assign w_s        = (PROB_W+1)'(r_s3_lo) + w_step_rnd[PROB_W+FRAC_W:FRAC_W];
    // negative logit mirrors around one
    assign w_p        = r_s3_neg ? ((PROB_W+1)'(65536) - w_s) : w_s;
    assign w_prob     = w_p[PROB_W] ? {PROB_W{1'b1}} : w_p[PROB_W-1:0];

    t_kind               r_s4_kind;
    logic [CORNER_W-1:0] r_s4_x_min, r_s4_y_min, r_s4_x_max, r_s4_y_max;
    logic [PROB_W-1:0]   r_s4_prob;

    always_ff @(posedge i_clk) begin
        if (w_adv4) begin
            r_s4_kind <= r_s3_kind;
            if (r_s3_kind == KIND_BOX) begin
                r_s4_x_min <= r_s3_x_min;
                r_s4_y_min <= r_s3_y_min;
                r_s4_x_max <= r_s3_x_max;
                r_s4_y_max <= r_s3_y_max;
                r_s4_prob  <= '0;
            end else begin
                r_s4_x_min <= '0;
                r_s4_y_min <= '0;
                r_s4_x_max <= '0;
                r_s4_y_max <= '0;
                r_s4_prob  <= w_prob;
            end
        end
    end

    assign m_axis_tvalid = r_v4;
    assign m_axis_tuser  = r_s4_kind;
    assign m_axis_tdata  = {r_s4_prob, r_s4_y_max, r_s4_x_max, r_s4_y_min, r_s4_x_min};

`ifndef ASSERT_OFF
    // a score word never carries corners
    a_score_no_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[0] == KIND_SCORE) |-> m_axis_tdata[111:0] == '0)
        else $error("score word with nonzero corners");

    // a box word never carries a probability
    a_box_no_prob: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[0] == KIND_BOX) |-> m_axis_tdata[127:112] == '0)
        else $error("box word with nonzero probability");

    // input side only backs up when the output is full and stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready && r_v1 && r_v2 && r_v3)
        else $error("input stalled with room in the pipeline");

    // table index stays inside the table
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> r_s1_idx <= IDX_W'(SIGMOID_TABLE_ENTRIES))
        else $error("sigmoid table index out of range");
`endif

endmodule

@@ dv/detection_box_and_score_decode_tb.sv @@
// ----------------------------------------------------------------------------
// detection_box_and_score_decode_tb
// self-checking bench for the ltrb box decode and sigmoid score stage
// ----------------------------------------------------------------------------
// Streams box words and score words into the block and predicts every result
// word from an independent model of the decode. The model covers the
// anchor-minus/plus-distance corners times the stride with 28-bit saturation,
// and the interpolated, mirrored sigmoid table. Results are compared field by
// field in order. A directed list covers field extremes, odd strides and
// sigmoid corner points. Random words follow, with bursts of idling on both
// sides, one long output stall that backs up the pipeline, and a drain pause
// on the input side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module detection_box_and_score_decode_tb
    import dbsd_pkg::*;
();

    localparam int     ROM_SEGMENTS = 256;
    localparam longint Q30_UNITY    = 64'd1 << 30;
    localparam longint CORNER_HI    = 134217727;
    localparam longint CORNER_LO    = -134217728;
    localparam int     HOLD_CYCLES  = 120;
    localparam int     TAIL_CYCLES  = 12;   // pipeline is four deep

    // one input word, unpacked
    typedef struct {
        t_kind              action;
        logic signed [19:0] left_dist;
        logic signed [19:0] top_dist;
        logic signed [19:0] right_dist;
        logic signed [19:0] bottom_dist;
        logic [18:0]        anchor_x;
        logic [18:0]        anchor_y;
        logic [6:0]         level_stride;
        logic signed [15:0] class_logit;
    } head_item_t;

    // one result word, unpacked
    typedef struct {
        t_kind       kind;
        logic [27:0] x_min;
        logic [27:0] y_min;
        logic [27:0] x_max;
        logic [27:0] y_max;
        logic [15:0] probability;
    } decoded_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;

    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // left_dist, top_dist, right_dist, bottom_dist, anchor_x, anchor_y,
    // level_stride, class_logit, 3 zero bits
    logic [143:0] s_axis_tdata = '0;
    // action
    logic [0:0]   s_axis_tuser = '0;

    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // x_min, y_min, x_max, y_max, probability
    logic [127:0] m_axis_tdata;
    // result_kind
    logic [0:0]   m_axis_tuser;

    // sigmoid table of the model, 0..8 in ROM_SEGMENTS steps
    logic [15:0]  sigmoid_points [0:ROM_SEGMENTS];

    head_item_t   head_items_to_send [$];
    decoded_t     expected_decodes [$];
    head_item_t   offered_item;

    int           queued_count   = 0;
    int           accepted_count = 0;
    int           mismatch_count = 0;

    // knobs from the stimulus process
    logic         idle_enable  = 1'b1;
    logic         hold_request = 1'b0;

    // driver and receiver bookkeeping
    logic         in_taken = 1'b0;
    int           send_gap = 0;
    int           stall_left = 0;
    int           hold_cycles_left = 0;
    logic         hold_done = 1'b0;

    always #5 i_clk = ~i_clk;

    detection_box_and_score_decode #(
        .SIGMOID_TABLE_ENTRIES(ROM_SEGMENTS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // ------------------------------------------------------------------------
    // sigmoid table: exp(-i/N) by series in q30, squared three times to reach
    // exp(-8i/N), then round(65536 / (1 + e)) capped at 65535
    // ------------------------------------------------------------------------
    initial begin : build_sigmoid_points
        logic [63:0] y;
        logic [63:0] e;
        logic [63:0] term;
        logic [63:0] den;
        logic [63:0] q;
        for (int i = 0; i <= ROM_SEGMENTS; i++) begin
            y    = (64'(i) << 30) / 64'(ROM_SEGMENTS);
            term = Q30_UNITY;
            e    = Q30_UNITY;
            for (int k = 1; k <= 20; k++) begin
                term = ((term * y) >> 30) / 64'(k);
                if (k % 2 == 1) begin
                    e = e - term;
                end else begin
                    e = e + term;
                end
            end
            repeat (3) e = (e * e) >> 30;
            den = Q30_UNITY + e;
            q   = ((64'd1 << 47) + den) / (den << 1);
            sigmoid_points[i] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
        end
    end

    // anchor -/+ distance, times stride, clamped to 28-bit signed
    function automatic logic [27:0] scaled_corner(logic [18:0] anchor,
                                                  logic signed [19:0] offset,
                                                  bit add, logic [6:0] stride);
        longint v;
        v = add ? longint'(anchor) + longint'(offset) : longint'(anchor) - longint'(offset);
        v = v * longint'(stride);
        if (v > CORNER_HI) v = CORNER_HI;
        if (v < CORNER_LO) v = CORNER_LO;
        return v[27:0];
    endfunction

    // expected result word for one input word
    function automatic decoded_t decode_head_item(head_item_t w);
        decoded_t    r;
        longint      mag;
        logic [63:0] pos;
        logic [63:0] idx;
        logic [63:0] frac;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] diff;
        logic [63:0] s;
        logic [63:0] p;
        r.kind        = w.action;
        r.x_min       = '0;
        r.y_min       = '0;
        r.x_max       = '0;
        r.y_max       = '0;
        r.probability = '0;
        if (w.action == KIND_BOX) begin
            r.x_min = scaled_corner(w.anchor_x, w.left_dist,   1'b0, w.level_stride);
            r.y_min = scaled_corner(w.anchor_y, w.top_dist,    1'b0, w.level_stride);
            r.x_max = scaled_corner(w.anchor_x, w.right_dist,  1'b1, w.level_stride);
            r.y_max = scaled_corner(w.anchor_y, w.bottom_dist, 1'b1, w.level_stride);
        end else begin
            mag  = (w.class_logit < 0) ? -longint'(w.class_logit) : longint'(w.class_logit);
            pos  = 64'(mag) * 64'(ROM_SEGMENTS);
            idx  = pos >> 15;
            frac = pos & 64'h7FFF;
            if (idx >= 64'(ROM_SEGMENTS)) begin
                // magnitude of 8 reads the last table point
                s = 64'(sigmoid_points[ROM_SEGMENTS]);
            end else begin
                lo   = 64'(sigmoid_points[idx]);
                hi   = 64'(sigmoid_points[idx + 1]);
                diff = (hi >= lo) ? hi - lo : 64'd0;
                s    = lo + ((diff * frac + 64'd16384) >> 15);
            end
            // mirror for negative logits, then cap at the ceiling
            p = (w.class_logit < 0) ? 64'd65536 - s : s;
            if (p > 64'd65535) p = 64'd65535;
            r.probability = p[15:0];
        end
        return r;
    endfunction

    // random word, weighted toward field extremes and common strides
    function automatic head_item_t random_word();
        head_item_t w;
        logic signed [19:0] d [4];
        for (int n = 0; n < 4; n++) begin
            case ($urandom_range(0, 7))
                0:       d[n] = 20'h80000;
                1:       d[n] = 20'h7FFFF;
                2, 3:    d[n] = 20'($signed($urandom_range(0, 4095)) - 2048);
                default: d[n] = 20'($urandom);
            endcase
        end
        w.action      = t_kind'($urandom_range(0, 1));
        w.left_dist   = d[0];
        w.top_dist    = d[1];
        w.right_dist  = d[2];
        w.bottom_dist = d[3];
        case ($urandom_range(0, 7))
            0:       begin w.anchor_x = '0;     w.anchor_y = '1;     end
            1:       begin w.anchor_x = '1;     w.anchor_y = '0;     end
            default: begin w.anchor_x = 19'($urandom); w.anchor_y = 19'($urandom); end
        endcase
        case ($urandom_range(0, 15))
            0:       w.level_stride = 7'd0;
            1:       w.level_stride = 7'($urandom_range(65, 127));
            2, 3:    w.level_stride = 7'd64;
            default: w.level_stride = 7'($urandom_range(1, 64));
        endcase
        case ($urandom_range(0, 9))
            0:       w.class_logit = 16'h8000;
            1:       w.class_logit = 16'h7FFF;
            2, 3:    w.class_logit = 16'($signed($urandom_range(0, 1023)) - 512);
            default: w.class_logit = 16'($urandom);
        endcase
        return w;
    endfunction

    // box word with given geometry, logit left random
    function automatic head_item_t box_item(int l, int t, int r, int b,
                                            int ax, int ay, int st);
        head_item_t w;
        w              = random_word();
        w.action       = KIND_BOX;
        w.left_dist    = 20'(l);
        w.top_dist     = 20'(t);
        w.right_dist   = 20'(r);
        w.bottom_dist  = 20'(b);
        w.anchor_x     = 19'(ax);
        w.anchor_y     = 19'(ay);
        w.level_stride = 7'(st);
        return w;
    endfunction

    // score word with given logit, box fields left random
    function automatic head_item_t score_item(int logit);
        head_item_t w;
        w             = random_word();
        w.action      = KIND_SCORE;
        w.class_logit = 16'(logit);
        return w;
    endfunction

    task automatic queue_word(head_item_t w);
        head_items_to_send.push_back(w);
        queued_count++;
    endtask

    task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // input driver: changes on the falling edge, moves to the next word once
    // the current one was taken at the last rising edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_input
        head_item_t w;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (send_gap > 0) begin
                send_gap      <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (head_items_to_send.size() != 0) begin
                w = head_items_to_send.pop_front();
                offered_item  <= w;
                s_axis_tdata  <= {3'b000, w.class_logit, w.level_stride, w.anchor_y,
                                  w.anchor_x, w.bottom_dist, w.right_dist, w.top_dist,
                                  w.left_dist};
                s_axis_tuser  <= w.action;
                s_axis_tvalid <= 1'b1;
                // idle burst after this word
                if (idle_enable && $urandom_range(0, 5) == 0) begin
                    send_gap <= $urandom_range(1, 18);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // output ready: one long hold on request, otherwise random stall bursts
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_cycles_left > 0) begin
            hold_cycles_left <= hold_cycles_left - 1;
            m_axis_tready    <= 1'b0;
        end else if (hold_request && !hold_done) begin
            // long hold so the pipeline fills and drops tready
            hold_cycles_left <= HOLD_CYCLES - 1;
            hold_done        <= 1'b1;
            m_axis_tready    <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 7) == 0) begin
            stall_left    <= $urandom_range(1, 18) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: check each result word against the oldest expectation, then
    // record the expectation for a word taken at this edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_ports
        decoded_t want;
        decoded_t got;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind        = t_kind'(m_axis_tuser[0]);
                got.x_min       = m_axis_tdata[27:0];
                got.y_min       = m_axis_tdata[55:28];
                got.x_max       = m_axis_tdata[83:56];
                got.y_max       = m_axis_tdata[111:84];
                got.probability = m_axis_tdata[127:112];
                if (expected_decodes.size() == 0) begin
                    $display("%0t ns: result word with none expected, actual kind %0h data %0h",
                             $time, m_axis_tuser, m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_decodes.pop_front();
                    report_field("result_kind", 32'(want.kind),        32'(got.kind));
                    report_field("x_min",       32'(want.x_min),       32'(got.x_min));
                    report_field("y_min",       32'(want.y_min),       32'(got.y_min));
                    report_field("x_max",       32'(want.x_max),       32'(got.x_max));
                    report_field("y_max",       32'(want.y_max),       32'(got.y_max));
                    report_field("probability", 32'(want.probability), 32'(got.probability));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_decodes.push_back(decode_head_item(offered_item));
                accepted_count++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int random_sent;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed boxes: extremes of distance, anchor and stride
        queue_word(box_item(524287, 524287, 524287, 524287, 524287, 524287, 127));
        queue_word(box_item(-524288, -524288, -524288, -524288, 524287, 524287, 127));
        queue_word(box_item(524287, 524287, 524287, 524287, 0, 0, 127));
        queue_word(box_item(-524288, 524287, -524288, 524287, 0, 524287, 1));
        queue_word(box_item(0, 0, 0, 0, 262144, 262144, 1));
        queue_word(box_item(12345, -777, 99999, -3, 40000, 70000, 0));      // stride zero
        queue_word(box_item(-256, 256, 512, -512, 1024, 2048, 64));
        queue_word(box_item(-256, 256, 512, -512, 1024, 2048, 65));         // above 64
        queue_word(box_item(-1, 1, -1, 1, 0, 0, 8));

        // directed scores: zero, smallest steps, saturation, exact table
        // points, half-step rounding, both signs
        queue_word(score_item(0));
        queue_word(score_item(1));
        queue_word(score_item(-1));
        queue_word(score_item(32767));
        queue_word(score_item(-32768));
        queue_word(score_item(-32767));
        queue_word(score_item(4096));
        queue_word(score_item(-4096));
        queue_word(score_item(128));
        queue_word(score_item(64));
        queue_word(score_item(-64));
        queue_word(score_item(32640));
        queue_word(score_item(16384));

        // sender pause until every expected result is back
        while (accepted_count != queued_count || expected_decodes.size() != 0) begin
            @(negedge i_clk);
        end

        // steady stream with a long output hold in the middle of it
        idle_enable <= 1'b0;
        repeat (200) queue_word(random_word());
        hold_request <= 1'b1;
        random_sent = 200;

        // random batches, some idling and some not
        while (random_sent < 780) begin
            while (head_items_to_send.size() > 8) @(negedge i_clk);
            idle_enable <= ($urandom_range(0, 3) != 0);
            repeat (50) queue_word(random_word());
            random_sent += 50;
        end

        // last stretch at full rate
        while (head_items_to_send.size() > 8) @(negedge i_clk);
        idle_enable <= 1'b0;
        repeat (150) queue_word(random_word());

        while (accepted_count != queued_count || expected_decodes.size() != 0) begin
            @(negedge i_clk);
        end
        // catch any stray word after the last expected one
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // run limit, far beyond the slowest legal run
    initial begin
        #3000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
